// ===== hdl/frst_pkg.sv =====
// shared types and codes for the fenwick range sum table
package frst_pkg;

	localparam int DATA_W = 32;

	typedef logic [DATA_W-1:0] word_t;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_SET   = 2'd1,
		ACT_RANGE = 2'd2,
		ACT_GET   = 2'd3
	} action_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		word_t   a;
		word_t   b;
	} alu_req_t;

endpackage

// ===== hdl/frst_alu.sv =====
// shared 32-bit add/subtract unit, wrapping two's complement
module frst_alu
	import frst_pkg::*;
(
	input  alu_req_t req,
	output word_t    y
);

	always_comb begin
		case (req.op)
			ALU_ADD: y = req.a + req.b;
			ALU_SUB: y = req.a - req.b;
			default: y = req.a + req.b;
		endcase
	end

endmodule

// ===== hdl/frst_mem.sv =====
// partial sum store, one write port and one registered read port
module frst_mem
	import frst_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  word_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output word_t         rdata
);

	word_t mem [DEPTH];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/fenwick_range_sum_table.sv =====
// fenwick range sum table top level: sequencer, index walk and result register
//
//  channel | dir | word                                         | accepted when
//  s_*     | in  | tuser action, tdata position/range_end/value | s_tvalid && s_tready
//  m_*     | out | tdata total                                  | m_tvalid && m_tready
//
// after reset a clearing pass writes zero to all TREE_SIZE entries with s_tready low.
// a prefix walk reads one node per set bit of its bound, all reads going through the
// single memory read port. range sum and get: two walks, a subtract, then the result
// waits in m_tdata until taken. add: a read, then a write through the shared adder,
// for each node on the update walk. set: both walks, subtract, difference, then the
// add walk. s_tready is high only while idle.
module fenwick_range_sum_table
	import frst_pkg::*;
#(
	parameter int TREE_SIZE = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // position[9:0], range_end[20:10], value[52:21], zeros
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // total[31:0]
);

	localparam int AW = (TREE_SIZE > 1) ? $clog2(TREE_SIZE) : 1;
	localparam int KW = $clog2(TREE_SIZE + 1);
	localparam int BW = (KW > 11) ? KW : 11;
	localparam int IW = BW + 1;
	localparam logic [IW-1:0] LIM = IW'(TREE_SIZE);
	localparam logic [AW-1:0] CLR_LAST = AW'(TREE_SIZE - 1);

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_PFX    = 8'b0000_0100,
		ST_SUB    = 8'b0000_1000,
		ST_DIFF   = 8'b0001_0000,
		ST_UPD_RD = 8'b0010_0000,
		ST_UPD_WR = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] lo_q;
	logic          second_q;
	logic          rd_pend_q;
	action_t       act_q;
	logic [9:0]    pos_q;
	word_t         val_q;
	word_t         acc_q;
	word_t         hold_q;
	word_t         res_q;
	word_t         amt_q;

	logic [9:0]    in_pos;
	logic [10:0]   in_end;
	word_t         in_val;
	action_t       in_act;
	logic [IW-1:0] in_pos_w;
	logic [IW-1:0] in_pos1_w;
	logic [IW-1:0] in_end_w;
	logic [IW-1:0] idx_m1;
	logic [IW-1:0] lowbit;

	alu_req_t alu_req;
	word_t    alu_y;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	word_t         mem_wdata;
	logic          mem_re;
	word_t         mem_rdata;

	function automatic logic [IW-1:0] sat(input logic [IW-1:0] b);
		sat = (b > LIM) ? LIM : b;
	endfunction

	assign in_pos    = s_tdata[9:0];
	assign in_end    = s_tdata[20:10];
	assign in_val    = s_tdata[52:21];
	assign in_act    = action_t'(s_tuser);
	assign in_pos_w  = IW'(in_pos);
	assign in_pos1_w = IW'(in_pos) + IW'(1);
	assign in_end_w  = IW'(in_end);

	assign idx_m1 = idx_q - IW'(1);
	assign lowbit = idx_q & (~idx_q + IW'(1));

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = res_q;

	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = acc_q;
		alu_req.b  = mem_rdata;
		case (state_q)
			ST_SUB: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = hold_q;
				alu_req.b  = acc_q;
			end
			ST_DIFF: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = val_q;
				alu_req.b  = res_q;
			end
			ST_UPD_WR: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = mem_rdata;
				alu_req.b  = amt_q;
			end
			default: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = acc_q;
				alu_req.b  = mem_rdata;
			end
		endcase
	end

	frst_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_UPD_WR);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : idx_m1[AW-1:0];
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : alu_y;
	assign mem_re    = ((state_q == ST_PFX) && (idx_q != '0)) ||
	                   ((state_q == ST_UPD_RD) && (idx_q <= LIM));

	frst_mem #(
		.DEPTH (TREE_SIZE),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (idx_m1[AW-1:0]),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			second_q  <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					second_q  <= 1'b0;
					rd_pend_q <= 1'b0;
					if (s_tvalid) begin
						case (in_act)
							ACT_ADD: begin
								if (in_pos_w < LIM) begin
									state_q <= ST_UPD_RD;
								end
							end
							ACT_SET: begin
								if (in_pos_w < LIM) begin
									state_q <= ST_PFX;
								end
							end
							default: state_q <= ST_PFX;
						endcase
					end
				end
				ST_PFX: begin
					rd_pend_q <= (idx_q != '0);
					if ((idx_q == '0) && !rd_pend_q) begin
						if (second_q) begin
							state_q <= ST_SUB;
						end else begin
							second_q <= 1'b1;
						end
					end
				end
				ST_SUB: begin
					state_q <= (act_q == ACT_SET) ? ST_DIFF : ST_OUT;
				end
				ST_DIFF: state_q <= ST_UPD_RD;
				ST_UPD_RD: begin
					state_q <= (idx_q > LIM) ? ST_IDLE : ST_UPD_WR;
				end
				ST_UPD_WR: state_q <= ST_UPD_RD;
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				act_q <= in_act;
				pos_q <= in_pos;
				val_q <= in_val;
				amt_q <= in_val;
				acc_q <= '0;
				case (in_act)
					ACT_ADD: idx_q <= in_pos1_w;
					ACT_RANGE: begin
						idx_q <= sat(in_end_w);
						lo_q  <= sat(in_pos_w);
					end
					default: begin
						idx_q <= sat(in_pos1_w);
						lo_q  <= sat(in_pos_w);
					end
				endcase
			end
			ST_PFX: begin
				if (idx_q != '0) begin
					idx_q <= idx_q - lowbit;
				end
				if (rd_pend_q) begin
					acc_q <= alu_y;
				end else if ((idx_q == '0) && !second_q) begin
					hold_q <= acc_q;
					acc_q  <= '0;
					idx_q  <= lo_q;
				end
			end
			ST_SUB: res_q <= alu_y;
			ST_DIFF: begin
				amt_q <= alu_y;
				idx_q <= IW'(pos_q) + IW'(1);
			end
			ST_UPD_WR: idx_q <= idx_q + lowbit;
			default: begin
			end
		endcase
	end

endmodule

// ===== verif/tb_fenwick_range_sum_table.sv =====
// regression testbench for the fenwick range sum table, checked against a scoreboard
`timescale 1ns / 100ps

module tb_fenwick_range_sum_table
	import frst_pkg::*;
();

	localparam int TREE_N     = 1024;
	localparam int STALL_MAX  = 19;
	localparam int LONG_HOLD  = 400;
	localparam int IDLE_LIMIT = 5000;
	localparam int TAIL_WAIT  = 100;

	class range_sum_scoreboard;
		word_t partial_sums[TREE_N];
		word_t expected_totals[$];
		int    mismatches;

		function new();
			foreach (partial_sums[i])
				partial_sums[i] = '0;
			mismatches = 0;
		endfunction

		function word_t prefix_sum(int unsigned bound);
			word_t       acc;
			int unsigned b;
			acc = '0;
			b = (bound > TREE_N) ? TREE_N : bound;
			while (b != 0) begin
				acc += partial_sums[b-1];
				b -= b & (~b + 1);
			end
			return acc;
		endfunction

		function word_t span_sum(int unsigned lo, int unsigned hi);
			return prefix_sum(hi) - prefix_sum(lo);
		endfunction

		function void bump(int unsigned pos, word_t amount);
			int unsigned k;
			if (pos >= TREE_N)
				return;
			for (k = pos + 1; k <= TREE_N; k += k & (~k + 1))
				partial_sums[k-1] += amount;
		endfunction

		function void note_word(action_t act, logic [9:0] pos, logic [10:0] upper, word_t val);
			case (act)
				ACT_ADD: begin
					bump(pos, val);
				end
				ACT_SET: begin
					if (pos < TREE_N)
						bump(pos, val - span_sum(pos, pos + 1));
				end
				ACT_RANGE: begin
					expected_totals.push_back(span_sum(pos, upper));
				end
				default: begin
					expected_totals.push_back((pos < TREE_N) ? span_sum(pos, pos + 1) :
						word_t'(0));
				end
			endcase
		endfunction

		function void check_total(word_t actual);
			word_t want;
			if (expected_totals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected total 0x%08h with nothing pending", actual);
				return;
			end
			want = expected_totals.pop_front();
			if (want !== actual) begin
				mismatches++;
				if (mismatches <= 10)
					$display("total mismatch: expected %0d (0x%08h) got %0d (0x%08h)",
						$signed(want), want, $signed(actual), actual);
			end
		endfunction

		function int pending();
			return expected_totals.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;   // position[9:0], range_end[20:10], value[52:21], zeros
	logic [1:0]  s_tuser = '0;   // action[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // total[31:0]

	range_sum_scoreboard sb = new();

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit long_hold_req = 1'b0;
	int idle_cycles = 0;

	fenwick_range_sum_table #(
		.TREE_SIZE(TREE_N)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// results first: a word taken at this edge cannot have produced one yet
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_total(m_tdata);
		if (s_tvalid && s_tready)
			sb.note_word(action_t'(s_tuser), s_tdata[9:0], s_tdata[20:10], s_tdata[52:21]);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("fenwick_range_sum_table regression: fail");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
				long_hold_req = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, STALL_MAX) - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_word(action_t act, logic [9:0] pos, logic [10:0] upper, word_t val);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {3'b000, val, upper, pos};
		do
			@(posedge clk);
		while (!s_tready);
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, STALL_MAX)) @(posedge clk);
		end
	endtask

	task automatic send_random_word();
		action_t     act;
		logic [9:0]  pos;
		logic [10:0] upper;
		word_t       val;
		int          pick;
		int          p;
		pick = $urandom_range(0, 9);
		act = (pick < 3) ? ACT_ADD : (pick < 5) ? ACT_SET : (pick < 8) ? ACT_RANGE : ACT_GET;
		case ($urandom_range(0, 3))
			0: pos = 10'($urandom_range(0, 63));
			1: pos = 10'($urandom_range(960, 1023));
			default: pos = 10'($urandom_range(0, TREE_N - 1));
		endcase
		p = int'(pos);
		pick = $urandom_range(0, 9);
		if (pick < 6)
			upper = 11'($urandom_range(0, TREE_N));
		else if (pick == 6)
			upper = 11'(TREE_N);
		else if (pick == 7)
			upper = 11'($urandom_range(TREE_N + 1, 2047));
		else
			upper = 11'($urandom_range((p < 3) ? 0 : p - 3, p + 3));
		val = ($urandom_range(0, 3) == 0) ? word_t'($urandom_range(0, 15)) - 8 : word_t'($urandom);
		send_word(act, pos, upper, val);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, extremes, wrap, reversed and clipped ranges
		send_word(ACT_GET,   10'd0,    11'd0,    32'h0000_0000);
		send_word(ACT_RANGE, 10'd0,    11'd1024, 32'h0000_0000);
		send_word(ACT_ADD,   10'd0,    11'd0,    32'h7fff_ffff);
		send_word(ACT_ADD,   10'd1023, 11'd0,    32'h8000_0000);
		send_word(ACT_ADD,   10'd0,    11'd0,    32'h0000_0001);
		send_word(ACT_GET,   10'd0,    11'd0,    32'h0000_0000);
		send_word(ACT_GET,   10'd1023, 11'd0,    32'h0000_0000);
		send_word(ACT_RANGE, 10'd0,    11'd1024, 32'h0000_0000);
		send_word(ACT_SET,   10'd512,  11'd0,    32'hffff_ffff);
		send_word(ACT_SET,   10'd0,    11'd0,    32'h0000_0000);
		send_word(ACT_GET,   10'd0,    11'd0,    32'h0000_0000);
		send_word(ACT_RANGE, 10'd1023, 11'd0,    32'h0000_0000);
		send_word(ACT_RANGE, 10'd513,  11'd512,  32'h0000_0000);
		send_word(ACT_RANGE, 10'd5,    11'd5,    32'h0000_0000);
		send_word(ACT_RANGE, 10'd0,    11'd2047, 32'hffff_ffff);
		send_word(ACT_RANGE, 10'd1023, 11'd1024, 32'h0000_0000);
		send_word(ACT_RANGE, 10'd1023, 11'd1500, 32'h0000_0000);
		send_word(ACT_ADD,   10'd511,  11'd0,    32'h5555_5555);
		send_word(ACT_SET,   10'd511,  11'd0,    32'haaaa_aaaa);
		send_word(ACT_GET,   10'd511,  11'd2047, 32'hffff_ffff);
		send_word(ACT_RANGE, 10'd0,    11'd0,    32'h0000_0000);
		send_word(ACT_ADD,   10'd300,  11'd2047, 32'h1234_5678);
		send_word(ACT_RANGE, 10'd300,  11'd301,  32'h0000_0000);
		send_word(ACT_SET,   10'd1023, 11'd0,    32'h7fff_ffff);
		send_word(ACT_RANGE, 10'd1000, 11'd1024, 32'h0000_0000);

		repeat (700) send_random_word();

		// receiver holds off while the sender keeps offering words
		tx_idle_on = 1'b0;
		long_hold_req = 1'b1;
		repeat (30) send_random_word();
		wait_for_drain();
		tx_idle_on = 1'b1;

		rx_idle_on = 1'b1;
		tx_idle_on = 1'b0;
		repeat (250) send_random_word();
		rx_idle_on = 1'b0;
		tx_idle_on = 1'b1;
		repeat (250) send_random_word();

		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (600) send_random_word();

		wait_for_drain();
		repeat (TAIL_WAIT) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("fenwick_range_sum_table regression: pass");
		else
			$display("fenwick_range_sum_table regression: fail");
		$finish;
	end

endmodule
